// ===== rtl/stm_pkg.sv =====
`timescale 1ns / 1ps

package stm_pkg;

  localparam int WINDOW_LENGTH = 16;
  localparam int TRIM_COUNT = 4;
  localparam int SAMPLE_BITS = 16;

  localparam int SAMPLE_PORT_BITS = 16;
  localparam int OUT_BITS = 16;

  localparam int KEEP = WINDOW_LENGTH - 2 * TRIM_COUNT;
  localparam bit KEEP_OK = (KEEP > 0);
  localparam int KEEP_DIV = KEEP_OK ? KEEP : 1;

  localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_LENGTH + 1);
  localparam int CNT_BITS = $clog2(WINDOW_LENGTH);

  // A reciprocal with SUM_BITS + clog2(KEEP_DIV) fraction bits, rounded up, gives
  // the exact truncated quotient for every dividend that fits in SUM_BITS.
  localparam int DIV_SHIFT = SUM_BITS + $clog2(KEEP_DIV);
  localparam int DIV_MUL_BITS = SUM_BITS + 1;
  localparam int PROD_BITS = SUM_BITS + DIV_MUL_BITS;
  localparam longint unsigned DIV_MUL =
    ((64'd1 << DIV_SHIFT) + 64'(KEEP_DIV) - 64'd1) / 64'(KEEP_DIV);

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic upd;
    logic rot;
  } cell_cmd_t;

  typedef struct packed {
    sample_t t;
    logic    le;
  } link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/stm_sample_if.sv =====
`timescale 1ns / 1ps

interface stm_sample_if;
  logic valid;
  logic ready;
  logic [stm_pkg::SAMPLE_PORT_BITS-1:0] sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

// ===== rtl/stm_mean_if.sv =====
`timescale 1ns / 1ps

interface stm_mean_if;
  logic valid;
  logic ready;
  logic [stm_pkg::OUT_BITS-1:0] trimmed_mean;

  modport source(output valid, output trimmed_mean, input ready);
  modport sink(input valid, input trimmed_mean, output ready);
endinterface

// ===== rtl/stm_cell.sv =====
`timescale 1ns / 1ps

module stm_cell (
  input  logic               clk,
  input  logic               rst,
  input  stm_pkg::cell_cmd_t cmd,
  input  stm_pkg::sample_t   old_val,
  input  stm_pkg::sample_t   new_val,
  input  stm_pkg::sample_t   right_val,
  input  stm_pkg::link_t     left_link,
  input  logic               tail,
  output stm_pkg::sample_t   val,
  output stm_pkg::link_t     link
);

  logic             lt_old;
  stm_pkg::sample_t u;

  // The window with the oldest sample removed is seen here as link.t, and
  // link.le tells whether the new sample goes to the right of it.
  always_comb begin
    lt_old  = (val < old_val);
    link.t  = lt_old ? val : right_val;
    link.le = !tail && (link.t <= new_val);
    if (link.le) begin
      u = link.t;
    end else if (left_link.le) begin
      u = new_val;
    end else begin
      u = left_link.t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
    end else if (cmd.rot) begin
      val <= right_val;
    end else if (cmd.upd) begin
      val <= u;
    end
  end

endmodule

// ===== rtl/stm_div.sv =====
`timescale 1ns / 1ps

module stm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [stm_pkg::SUM_BITS-1:0] dividend,
  output logic                         busy,
  output logic [stm_pkg::SUM_BITS-1:0] quotient
);

  logic [stm_pkg::PROD_BITS-1:0] product;

  // The fixed divisor is applied as a multiply by its reciprocal; the quotient
  // is registered while busy is high; busy is registered from start.
  always_comb begin
    product = stm_pkg::PROD_BITS'(dividend) * stm_pkg::PROD_BITS'(stm_pkg::DIV_MUL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      quotient <= stm_pkg::SUM_BITS'(product >> stm_pkg::DIV_SHIFT);
    end
  end

endmodule

// ===== rtl/sliding_trimmed_mean_unit.sv =====
// The sorted cell chain updates in the transfer cycle, then rotates once around the
// ring to sum the kept entries; a reciprocal multiply divides the sum and the output
// register loads the mean once it is free. A new sample is taken only while idle, after
// the mean of the last one is loaded; the output register lets the next sample enter
// while a mean waits. Synchronous reset clears both windows.
`timescale 1ns / 1ps

module sliding_trimmed_mean_unit (
  input  logic clk,
  input  logic rst,
  stm_sample_if.sink samples,
  stm_mean_if.source means
);

  stm_pkg::state_t    state;
  stm_pkg::state_t    state_next;
  stm_pkg::cell_cmd_t cmd;
  stm_pkg::sample_t   arr [stm_pkg::WINDOW_LENGTH];
  stm_pkg::sample_t   vals [stm_pkg::WINDOW_LENGTH];
  stm_pkg::link_t     links [stm_pkg::WINDOW_LENGTH];
  stm_pkg::sample_t   new_val;

  logic [stm_pkg::CNT_BITS-1:0] cnt;
  logic [stm_pkg::SUM_BITS-1:0] acc;
  logic [stm_pkg::SUM_BITS-1:0] quotient;
  logic [stm_pkg::OUT_BITS-1:0] out_data;
  logic                         out_valid;
  logic                         in_ready;
  logic                         take;
  logic                         cnt_last;
  logic                         in_keep;
  logic                         div_start;
  logic                         div_busy;
  logic                         out_load;
  logic                         sorted_ok;

  assign new_val       = stm_pkg::SAMPLE_BITS'(samples.sample);
  assign take          = samples.valid && in_ready;
  assign samples.ready = in_ready;
  assign means.valid   = out_valid;
  assign means.trimmed_mean = out_data;
  assign cnt_last      = (cnt == stm_pkg::CNT_BITS'(stm_pkg::WINDOW_LENGTH - 1));
  assign in_keep       = stm_pkg::KEEP_OK && (int'(cnt) >= stm_pkg::TRIM_COUNT)
                         && (int'(cnt) < stm_pkg::WINDOW_LENGTH - stm_pkg::TRIM_COUNT);

  always_comb begin
    state_next = state;
    unique case (state)
      stm_pkg::ST_IDLE: if (take) state_next = stm_pkg::ST_SUM;
      stm_pkg::ST_SUM:  if (cnt_last) state_next = stm_pkg::ST_DIV;
      stm_pkg::ST_DIV:  if (!div_busy) state_next = stm_pkg::ST_OUT;
      stm_pkg::ST_OUT:  if (!out_valid || means.ready) state_next = stm_pkg::ST_IDLE;
      default:          state_next = stm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd.upd   = 1'b0;
    cmd.rot   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      stm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.upd  = samples.valid;
      end
      stm_pkg::ST_SUM: begin
        cmd.rot   = 1'b1;
        div_start = cnt_last;
      end
      stm_pkg::ST_DIV: begin
      end
      stm_pkg::ST_OUT: begin
        out_load = !out_valid || means.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == stm_pkg::ST_SUM) begin
      cnt <= cnt + 1'b1;
    end else begin
      cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      acc <= '0;
    end else if (state == stm_pkg::ST_SUM && in_keep) begin
      acc <= acc + stm_pkg::SUM_BITS'(vals[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < stm_pkg::WINDOW_LENGTH; k++) begin
        arr[k] <= '0;
      end
    end else if (take) begin
      for (int k = 0; k < stm_pkg::WINDOW_LENGTH - 1; k++) begin
        arr[k] <= arr[k+1];
      end
      arr[stm_pkg::WINDOW_LENGTH-1] <= new_val;
    end
  end

  for (genvar i = 0; i < stm_pkg::WINDOW_LENGTH; i++) begin : g_cell
    stm_pkg::sample_t right_val;
    stm_pkg::link_t   left_link;

    if (i == 0) begin : g_head
      assign left_link = '{t: '0, le: 1'b1};
    end else begin : g_body
      assign left_link = links[i-1];
    end

    if (i == stm_pkg::WINDOW_LENGTH - 1) begin : g_tail
      assign right_val = vals[0];
    end else begin : g_next
      assign right_val = vals[i+1];
    end

    stm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .old_val   (arr[0]),
      .new_val   (new_val),
      .right_val (right_val),
      .left_link (left_link),
      .tail      (1'(i == stm_pkg::WINDOW_LENGTH - 1)),
      .val       (vals[i]),
      .link      (links[i])
    );
  end

  stm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (means.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= stm_pkg::KEEP_OK ? stm_pkg::OUT_BITS'(quotient) : '0;
    end
  end

  always_comb begin
    sorted_ok = 1'b1;
    for (int k = 0; k < stm_pkg::WINDOW_LENGTH - 1; k++) begin
      if (vals[k] > vals[k+1]) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_take_starts_sum: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> state == stm_pkg::ST_SUM)
    else $error("Sample transfer did not start the summing pass.");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("Divider started while still busy.");

  a_chain_sorted: assert property (@(posedge clk) disable iff (rst)
    state == stm_pkg::ST_IDLE |-> sorted_ok)
    else $error("Sorted chain is out of order while idle.");

  a_load_free_slot: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || means.ready))
    else $error("Output register overwritten before its transfer.");

endmodule

// ===== dv/sliding_trimmed_mean_unit_tb.sv =====
`timescale 1ns / 1ps

module sliding_trimmed_mean_unit_tb;

  localparam int LATENCY = stm_pkg::WINDOW_LENGTH + 3;
  localparam int RANDOM_ITEMS = 1900;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT_ITEM = 1000;

  typedef struct packed {
    logic [stm_pkg::SAMPLE_PORT_BITS-1:0] value;
    logic typed;
    logic [stm_pkg::OUT_BITS-1:0] mean;
  } stim_row_t;

  logic clk;
  logic rst;

  stm_sample_if sample_ch ();
  stm_mean_if mean_ch ();

  sliding_trimmed_mean_unit dut (
    .clk(clk),
    .rst(rst),
    .samples(sample_ch),
    .means(mean_ch)
  );

  stm_pkg::sample_t arrival_hist [stm_pkg::WINDOW_LENGTH];
  logic [stm_pkg::OUT_BITS-1:0] pending_means [$];
  stim_row_t directed_rows [$];
  int mismatches;
  int samples_sent;
  int means_seen;
  int input_stall_cycles;
  bit quiet;
  bit hold_request;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Timeout with %0d means outstanding", pending_means.size());
    $display("Verification failed");
    $finish;
  end

  function automatic logic [stm_pkg::OUT_BITS-1:0] next_trimmed_mean(
    logic [stm_pkg::SAMPLE_PORT_BITS-1:0] raw
  );
    stm_pkg::sample_t sorted [stm_pkg::WINDOW_LENGTH];
    stm_pkg::sample_t v;
    logic [63:0] total;
    int b;
    total = '0;
    for (int k = 0; k + 1 < stm_pkg::WINDOW_LENGTH; k++) arrival_hist[k] = arrival_hist[k + 1];
    arrival_hist[stm_pkg::WINDOW_LENGTH - 1] = stm_pkg::sample_t'(raw);
    for (int a = 0; a < stm_pkg::WINDOW_LENGTH; a++) begin
      v = arrival_hist[a];
      b = a;
      while (b > 0 && sorted[b - 1] > v) begin
        sorted[b] = sorted[b - 1];
        b--;
      end
      sorted[b] = v;
    end
    if (!stm_pkg::KEEP_OK) return '0;
    for (int k = stm_pkg::TRIM_COUNT; k < stm_pkg::WINDOW_LENGTH - stm_pkg::TRIM_COUNT; k++) begin
      total += 64'(sorted[k]);
    end
    return stm_pkg::OUT_BITS'(total / 64'(stm_pkg::KEEP_DIV));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 50) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_sample(logic [stm_pkg::SAMPLE_PORT_BITS-1:0] value, logic typed,
                             logic [stm_pkg::OUT_BITS-1:0] want);
    int gap;
    logic [stm_pkg::OUT_BITS-1:0] predicted;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.sample <= value;
    do begin
      @(posedge clk);
      if (sample_ch.ready !== 1'b1) input_stall_cycles++;
    end while (sample_ch.ready !== 1'b1);
    predicted = next_trimmed_mean(value);
    pending_means.push_back(typed ? want : predicted);
    samples_sent++;
  endtask

  initial begin : mean_sink
    int stall_left;
    int hold_left;
    logic [stm_pkg::OUT_BITS-1:0] want;
    stall_left = 0;
    hold_left = 0;
    mean_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (mean_ch.valid === 1'b1 && mean_ch.ready === 1'b1) begin
        means_seen++;
        if (pending_means.size() == 0) begin
          report_mismatch($sformatf("unexpected mean %0d", mean_ch.trimmed_mean));
        end else begin
          want = pending_means.pop_front();
          if (mean_ch.trimmed_mean !== want) begin
            report_mismatch($sformatf("trimmed_mean %0d, expected %0d",
                                      mean_ch.trimmed_mean, want));
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        mean_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        mean_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        mean_ch.ready <= 1'b0;
      end else begin
        mean_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [stm_pkg::SAMPLE_PORT_BITS-1:0] value;
    logic [stm_pkg::SAMPLE_PORT_BITS-1:0] dup_value;
    int dup_left;
    int mode;
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.sample = '0;
    mismatches = 0;
    samples_sent = 0;
    means_seen = 0;
    input_stall_cycles = 0;
    quiet = 1'b0;
    hold_request = 1'b0;
    dup_left = 0;
    dup_value = '0;
    foreach (arrival_hist[k]) arrival_hist[k] = '0;

    // The reset zeros still fill the kept middle for the first four samples.
    for (int i = 0; i < 4; i++) directed_rows.push_back('{16'hFFFF, 1'b1, 16'h0000});
    for (int i = 0; i < 7; i++) directed_rows.push_back('{16'hFFFF, 1'b0, 16'h0000});
    for (int i = 0; i < 5; i++) directed_rows.push_back('{16'hFFFF, 1'b1, 16'hFFFF});
    // Four zeros fall entirely into the lower trimmed entries.
    for (int i = 0; i < 4; i++) directed_rows.push_back('{16'h0000, 1'b1, 16'hFFFF});
    directed_rows.push_back('{16'h0001, 1'b0, 16'h0000});
    directed_rows.push_back('{16'h8000, 1'b0, 16'h0000});
    directed_rows.push_back('{16'h7FFF, 1'b0, 16'h0000});
    directed_rows.push_back('{16'h1234, 1'b0, 16'h0000});
    directed_rows.push_back('{16'hAAAA, 1'b0, 16'h0000});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].mean);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 600 && n < 700) || (n >= HOLD_AT_ITEM && n < HOLD_AT_ITEM + 40);
      if (n == HOLD_AT_ITEM) hold_request = 1'b1;
      if (dup_left > 0) begin
        value = dup_value;
        dup_left--;
      end else begin
        mode = $urandom_range(0, 9);
        case (mode) inside
          [0:3]: value = 16'($urandom_range(0, 65535));
          4: begin
            case ($urandom_range(0, 4))
              0: value = 16'h0000;
              1: value = 16'hFFFF;
              2: value = 16'h8000;
              3: value = 16'h7FFF;
              default: value = 16'h0001 << $urandom_range(0, 15);
            endcase
          end
          [5:6]: value = 16'($urandom_range(0, 15));
          7: value = 16'hFFFF - 16'($urandom_range(0, 15));
          default: begin
            dup_value = 16'($urandom_range(0, 65535));
            dup_left = $urandom_range(3, 20);
            value = dup_value;
          end
        endcase
      end
      send_sample(value, 1'b0, '0);
    end

    sample_ch.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    $display("Sent %0d samples (directed table, then random values, extremes and runs of",
             samples_sent);
    $display("equal samples); checked %0d means; input stalled %0d cycles under back pressure.",
             means_seen, input_stall_cycles);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/stm_pkg.sv
rtl/stm_sample_if.sv
rtl/stm_mean_if.sv
rtl/stm_cell.sv
rtl/stm_div.sv
rtl/sliding_trimmed_mean_unit.sv
dv/sliding_trimmed_mean_unit_tb.sv
